@@ rtl/core/s256h_pkg.sv @@
// ----------------------------------------------------------------------------
// s256h_pkg - shared types and constants of the SHA-256 stream hasher
// Sequencer states, command bundles, round constants, initial hash values
// and the sigma functions.
// ----------------------------------------------------------------------------
package s256h_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_COMP,
		ST_FOLD,
		ST_OUT
	} state_t;

	// Message window commands
	typedef struct packed {
		logic       push;   // shift one byte in
		logic       shift;  // shift one expanded word in
		logic [7:0] din;
	} sched_cmd_t;

	// Round unit commands
	typedef struct packed {
		logic init;   // hash words back to initial values
		logic start;  // working vars <- hash words
		logic round;  // one compression round
		logic fold;   // hash words += working vars
	} round_cmd_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] FILL_TOP = 6'd63;
	localparam logic [5:0] RND_TOP  = 6'd63;
	localparam logic [2:0] WORD_TOP = 3'd7;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage

@@ rtl/core/s256h_sched.sv @@
// ----------------------------------------------------------------------------
// s256h_sched - block buffer and message schedule
// 512-bit window: bytes shift in during absorb, expanded words shift in
// during compression. The oldest word is the current round's W.
// ----------------------------------------------------------------------------
module s256h_sched (
	input  logic                   clk,
	input  s256h_pkg::sched_cmd_t  cmd,
	output logic [31:0]            w_t
);
	import s256h_pkg::*;

	logic [511:0] win_q;
	logic [31:0]  w_new;

	// word j (0 oldest) sits at win_q[511-32j -: 32]
	assign w_new = ssig1(win_q[63:32]) + win_q[223:192]
		+ ssig0(win_q[479:448]) + win_q[511:480];
	assign w_t = win_q[511:480];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[503:0], cmd.din};
		end else if (cmd.shift) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

endmodule

@@ rtl/core/s256h_round.sv @@
// ----------------------------------------------------------------------------
// s256h_round - compression round unit and hash words
// One round per cycle on the working variables a..h; fold adds them
// into the hash words.
// ----------------------------------------------------------------------------
module s256h_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  s256h_pkg::round_cmd_t  cmd,
	input  logic [31:0]            w_t,
	input  logic [31:0]            k_t,
	output logic [7:0][31:0]       hash
);
	import s256h_pkg::*;

	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] t1;
	logic [31:0] t2;

	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ k_t + w_t;
	assign t2 = bsig0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			v_q <= h_q;
		end else if (cmd.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= INIT_H;
		end else if (cmd.init) begin
			h_q <= INIT_H;
		end else if (cmd.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash[i] = h_q[i];
		end
	end

endmodule

@@ rtl/core/sha256_stream_hasher_top.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top - SHA-256 over a byte stream
// Absorbs one message byte per beat, pads on finish and streams out the
// eight digest words.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata               | tuser           | tlast
//  --------+-----------+---------------------+-----------------+-----------
//  s_axis  | in        | [7:0] data_byte     | [0] byte_valid  | finish
//  m_axis  | out       | [31:0] digest_word  | [2:0] word_index| last_word
//
// Block: the beat that fills a 64-byte block is followed by a busy phase
// (64 rounds on the shared round unit, then one fold).
// Finish: padding goes through the same window one byte at a time, plus one or
// two compressions, then eight output beats.
// Reset: arst_n clears the sequencer and counters and sets the hash words to their initial values at once.
// s_axis_tready is low while padding, compressing or emitting; m_axis stalls hold the word.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] byte_valid
	input  logic        s_axis_tlast,   // finish
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast    // last_word
);
	import s256h_pkg::*;

	state_t      state_q, state_n;
	state_t      ret_q, ret_n;     // where to go after a compression
	logic [5:0]  fill_q;           // bytes in the current block
	logic [60:0] byte_cnt_q;       // message length in bytes, wraps
	logic [5:0]  rnd_q;            // round number
	logic [2:0]  len_q;            // length byte being pushed
	logic [2:0]  oidx_q;           // digest word being emitted

	sched_cmd_t      scmd;
	round_cmd_t      rcmd;
	logic [31:0]     w_t;
	logic [7:0][31:0] hash;
	logic [63:0]     len_bits;
	logic [2:0]      len_sel;
	logic            in_beat;
	logic            out_beat;

	assign in_beat  = s_axis_tvalid & s_axis_tready;
	assign out_beat = m_axis_tvalid & m_axis_tready;

	// bit length, big-endian: byte 0 is bits [63:56]
	assign len_bits = {byte_cnt_q, 3'b000};
	assign len_sel  = ~len_q;

	s256h_sched u_sched (
		.clk (clk),
		.cmd (scmd),
		.w_t (w_t)
	);

	s256h_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.w_t    (w_t),
		.k_t    (ROUND_K[rnd_q]),
		.hash   (hash)
	);

	always_comb begin
		state_n       = state_q;
		ret_n         = ret_q;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		scmd          = '0;
		rcmd          = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser[0]) begin
						scmd.push = 1'b1;
						scmd.din  = s_axis_tdata;
					end
					// block full: compress, then pad if finishing
					if (s_axis_tuser[0] && fill_q == FILL_TOP) begin
						state_n    = ST_COMP;
						ret_n      = s_axis_tlast ? ST_PAD80 : ST_IDLE;
						rcmd.start = 1'b1;
					end else if (s_axis_tlast) begin
						state_n = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				scmd.push = 1'b1;
				scmd.din  = PAD_BYTE;
				if (fill_q == FILL_TOP) begin
					state_n    = ST_COMP;
					ret_n      = ST_PADZ;
					rcmd.start = 1'b1;
				end else begin
					state_n = ST_PADZ;
				end
			end
			ST_PADZ: begin
				if (fill_q == LEN_POS) begin
					state_n = ST_PADLEN;
				end else begin
					scmd.push = 1'b1;
					if (fill_q == FILL_TOP) begin
						state_n    = ST_COMP;
						ret_n      = ST_PADZ;
						rcmd.start = 1'b1;
					end
				end
			end
			ST_PADLEN: begin
				scmd.push = 1'b1;
				scmd.din  = len_bits[{len_sel, 3'b000} +: 8];
				if (len_q == WORD_TOP) begin
					state_n    = ST_COMP;
					ret_n      = ST_OUT;
					rcmd.start = 1'b1;
				end
			end
			ST_COMP: begin
				rcmd.round = 1'b1;
				scmd.shift = 1'b1;
				if (rnd_q == RND_TOP) begin
					state_n = ST_FOLD;
				end
			end
			ST_FOLD: begin
				rcmd.fold = 1'b1;
				state_n   = ret_q;
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready && oidx_q == WORD_TOP) begin
					rcmd.init = 1'b1;
					state_n   = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q      <= ST_IDLE;
			fill_q     <= '0;
			byte_cnt_q <= '0;
			rnd_q      <= '0;
			len_q      <= '0;
			oidx_q     <= '0;
		end else begin
			ret_q <= ret_n;
			if (scmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (in_beat && s_axis_tuser[0]) begin
				byte_cnt_q <= byte_cnt_q + 61'd1;
			end
			rnd_q <= (state_q == ST_COMP) ? rnd_q + 6'd1 : '0;
			len_q <= (state_q == ST_PADLEN) ? len_q + 3'd1 : '0;
			if (out_beat) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == WORD_TOP) begin
					fill_q     <= '0;
					byte_cnt_q <= '0;
				end
			end
		end
	end

	assign m_axis_tdata = hash[oidx_q];
	assign m_axis_tuser = oidx_q;
	assign m_axis_tlast = (oidx_q == WORD_TOP);

endmodule
